// File: rtl/grs_pkg.sv
// Package with the shared types and constants of the gimbal rate servo.
package grs_pkg;

    // Field widths of the streams and of the configuration port.
    localparam int Q_W       = 24;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int OUT_DAT_W = 80;

    // Input item kinds.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RATE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ANGLE = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SEC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WATTS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WATTS_RATE = 3'd7;

    // Register values after reset.
    localparam logic        RST_ENABLE     = 1'b1;
    localparam logic [19:0] RST_TICK_SEC   = 20'd10486;
    localparam logic [22:0] RST_MAX_RATE   = 23'd1048576;
    localparam logic [22:0] RST_MAX_ACCEL  = 23'd5242880;
    localparam logic [23:0] RST_LOW_LIMIT  = 24'hCDBC09;
    localparam logic [23:0] RST_HIGH_LIMIT = 24'h3243F7;
    localparam logic [14:0] RST_BASE_WATTS = 15'd50;
    localparam logic [9:0]  RST_WATTS_RATE = 10'd10;

    // Q4.20 saturation bounds and the 0.1 rad near-limit margin.
    localparam logic signed [Q_W-1:0] Q_MAX       = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN       = 24'sh800000;
    localparam logic signed [Q_W-1:0] NEAR_MARGIN = 24'sd104858;

    // Configuration register file contents.
    typedef struct packed {
        logic        enable;
        logic [19:0] tick_seconds;
        logic [22:0] max_rate;
        logic [22:0] max_accel;
        logic [23:0] low_angle_limit;
        logic [23:0] high_angle_limit;
        logic [14:0] base_watts;
        logic [9:0]  watts_per_rate;
    } t_cfg;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic decode;
        logic tgt;
        logic err;
        logic slew;
        logic inc;
        logic ang;
        logic pwr;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             enable;
        logic             out_busy;
    } t_dp_sts;

endpackage

// File: rtl/gimbal_rate_servo.sv
// Flow: an enabled tick steps through decode, target, error, slew, increment, angle,
// power and output; commands and disabled ticks go from decode to power and output.
// A new item is taken only back in idle, once the result register is loaded. The enabled
// tick uses the single shared multiplier in turn for the slew step, the angle increment
// and the power estimate, with the add steps between. Reset (synchronous, active low):
// registers return to their defaults, angle, rates and commands clear to zero in rate mode, and no result is pending.
module gimbal_rate_servo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [grs_pkg::Q_W-1:0]        s_axis_tdata,  // [23:0] value
    input  logic [grs_pkg::CMD_W-1:0]      s_axis_tuser,  // [1:0] cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [23:0] angle, [47:24] rate, [48] near_limit, [49] hit_limit, [73:50] power
    output logic [grs_pkg::OUT_DAT_W-1:0]  m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [grs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grs_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import grs_pkg::*;

    t_cfg            cfg;
    t_dp_cmd         dp_cmd;
    t_dp_sts         dp_sts;
    logic [Q_W-1:0]  out_angle;
    logic [Q_W-1:0]  out_rate;
    logic            out_near;
    logic            out_hit;
    logic [Q_W-1:0]  out_power;

    // Configuration registers.
    grs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Step sequencer.
    grs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Servo arithmetic and result register.
    grs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_cmd    (s_axis_tuser),
        .i_in_value  (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_angle (out_angle),
        .o_out_rate  (out_rate),
        .o_out_near  (out_near),
        .o_out_hit   (out_hit),
        .o_out_power (out_power)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_axis_tdata = {6'b000000, out_power, out_hit, out_near, out_rate, out_angle};

endmodule

// File: rtl/grs_cfg.sv
// Configuration register file of the gimbal rate servo.
module grs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [grs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grs_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output grs_pkg::t_cfg                  o_cfg
);
    import grs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; each register keeps the low bits of the data.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:     n_cfg.enable           = i_cfg_data[0];
                REG_TICK_SEC:   n_cfg.tick_seconds     = i_cfg_data[19:0];
                REG_MAX_RATE:   n_cfg.max_rate         = i_cfg_data[22:0];
                REG_MAX_ACCEL:  n_cfg.max_accel        = i_cfg_data[22:0];
                REG_LOW_LIMIT:  n_cfg.low_angle_limit  = i_cfg_data[23:0];
                REG_HIGH_LIMIT: n_cfg.high_angle_limit = i_cfg_data[23:0];
                REG_BASE_WATTS: n_cfg.base_watts       = i_cfg_data[14:0];
                REG_WATTS_RATE: n_cfg.watts_per_rate   = i_cfg_data[9:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= RST_ENABLE;
            r_cfg.tick_seconds     <= RST_TICK_SEC;
            r_cfg.max_rate         <= RST_MAX_RATE;
            r_cfg.max_accel        <= RST_MAX_ACCEL;
            r_cfg.low_angle_limit  <= RST_LOW_LIMIT;
            r_cfg.high_angle_limit <= RST_HIGH_LIMIT;
            r_cfg.base_watts       <= RST_BASE_WATTS;
            r_cfg.watts_per_rate   <= RST_WATTS_RATE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/grs_ctrl.sv
// Controller state machine that sequences the servo datapath.
module grs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  grs_pkg::t_dp_sts i_sts,
    output grs_pkg::t_dp_cmd o_cmd
);
    import grs_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_TGT  = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_SLEW = 4'd4;
    localparam logic [3:0] ST_INC  = 4'd5;
    localparam logic [3:0] ST_ANG  = 4'd6;
    localparam logic [3:0] ST_PWR  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Next state: an enabled tick runs the full servo step, all else only power.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_DEC;
            ST_DEC: begin
                if (i_sts.cmd == CMD_TICK && i_sts.enable) n_state = ST_TGT;
                else n_state = ST_PWR;
            end
            ST_TGT:  n_state = ST_ERR;
            ST_ERR:  n_state = ST_SLEW;
            ST_SLEW: n_state = ST_INC;
            ST_INC:  n_state = ST_ANG;
            ST_ANG:  n_state = ST_PWR;
            ST_PWR:  n_state = ST_OUT;
            ST_OUT:  if (!i_sts.out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Step commands decoded from the state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = in_fire;
        o_cmd.decode   = (r_state == ST_DEC);
        o_cmd.tgt      = (r_state == ST_TGT);
        o_cmd.err      = (r_state == ST_ERR);
        o_cmd.slew     = (r_state == ST_SLEW);
        o_cmd.inc      = (r_state == ST_INC);
        o_cmd.ang      = (r_state == ST_ANG);
        o_cmd.pwr      = (r_state == ST_PWR);
        o_cmd.out_load = (r_state == ST_OUT) && !i_sts.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted item always starts with the decode step.
    a_fire_to_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == ST_DEC)
        else $error("accepted item did not enter decode");

    // Loading the result ends the item.
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == ST_IDLE)
        else $error("result load did not return to idle");

endmodule

// File: rtl/grs_dp.sv
// Datapath of the gimbal rate servo: state, shared multiplier and result register.
module grs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  grs_pkg::t_cfg                i_cfg,
    input  grs_pkg::t_dp_cmd             i_cmd,
    output grs_pkg::t_dp_sts             o_sts,
    input  logic [grs_pkg::CMD_W-1:0]    i_in_cmd,
    input  logic [grs_pkg::Q_W-1:0]      i_in_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [grs_pkg::Q_W-1:0]      o_out_angle,
    output logic [grs_pkg::Q_W-1:0]      o_out_rate,
    output logic                         o_out_near,
    output logic                         o_out_hit,
    output logic [grs_pkg::Q_W-1:0]      o_out_power
);
    import grs_pkg::*;

    // Saturate a widened sum to the Q4.20 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+1:0] x);
        logic signed [Q_W-1:0] y;
        if (x > 26'(Q_MAX)) y = Q_MAX;
        else if (x < 26'(Q_MIN)) y = Q_MIN;
        else y = x[Q_W-1:0];
        return y;
    endfunction

    // Clamp with the low bound applied first, then the high bound.
    function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] x,
                                                      input logic signed [Q_W-1:0] lo,
                                                      input logic signed [Q_W-1:0] hi);
        logic signed [Q_W-1:0] y;
        y = x;
        if (y < lo) y = lo;
        if (y > hi) y = hi;
        return y;
    endfunction

    // Item and servo state.
    logic [CMD_W-1:0]        r_cmd;
    logic signed [Q_W-1:0]   r_val;
    logic signed [Q_W-1:0]   r_angle, n_angle;
    logic signed [Q_W-1:0]   r_rate, n_rate;
    logic signed [Q_W-1:0]   r_trc, n_trc;
    logic signed [Q_W-1:0]   r_tac, n_tac;
    logic                    r_mode, n_mode;
    logic                    r_hit, n_hit;

    // Intermediate step registers.
    logic signed [Q_W-1:0]   r_tgt;
    logic signed [Q_W-1:0]   r_err;
    logic [22:0]             r_step;
    logic signed [45:0]      r_prod;

    // Result register.
    logic                    r_out_valid;
    logic [Q_W-1:0]          r_out_angle;
    logic [Q_W-1:0]          r_out_rate;
    logic                    r_out_near;
    logic                    r_out_hit;
    logic [Q_W-1:0]          r_out_power;

    logic signed [Q_W-1:0]   lo_lim, hi_lim, mr_pos, mr_neg;
    logic signed [Q_W:0]     ang_diff;
    logic signed [Q_W+1:0]   tgt_dbl;
    logic signed [Q_W-1:0]   tgt_raw, tgt_clamped;
    logic [Q_W-1:0]          rate_mag, err_mag;
    logic signed [Q_W+1:0]   step_s, slew_sum;
    logic signed [Q_W-1:0]   inc, ang_sat;
    logic signed [Q_W-1:0]   lo_b, hi_b;
    logic signed [24:0]      mul_a;
    logic signed [20:0]      mul_b;
    logic signed [45:0]      mul_p;
    logic [Q_W-1:0]          power_sum;

    assign lo_lim = $signed(i_cfg.low_angle_limit);
    assign hi_lim = $signed(i_cfg.high_angle_limit);
    assign mr_pos = $signed({1'b0, i_cfg.max_rate});
    assign mr_neg = -mr_pos;

    // Target rate: commanded rate, or twice the angle error, clamped to max rate.
    assign ang_diff    = 25'(r_tac) - 25'(r_angle);
    assign tgt_dbl     = $signed({ang_diff, 1'b0});
    assign tgt_raw     = r_mode ? sat_q(tgt_dbl) : r_trc;
    assign tgt_clamped = clamp_q(tgt_raw, mr_neg, mr_pos);

    // Magnitudes for the slew test and the power estimate.
    assign rate_mag = r_rate[Q_W-1] ? 24'(-r_rate) : 24'(r_rate);
    assign err_mag  = r_err[Q_W-1] ? 24'(-r_err) : 24'(r_err);
    assign step_s   = $signed({3'b000, r_step});
    assign slew_sum = r_err[Q_W-1] ? 26'(r_rate) - step_s : 26'(r_rate) + step_s;

    // Angle increment is floor(rate * dt / 2^20) from the stored product.
    assign inc     = $signed(r_prod[43:20]);
    assign ang_sat = sat_q(26'(r_angle) + 26'(inc));

    // Near-limit bounds, each saturated.
    assign lo_b = sat_q(26'(lo_lim) + 26'(NEAR_MARGIN));
    assign hi_b = sat_q(26'(hi_lim) - 26'(NEAR_MARGIN));

    // Shared multiplier: slew step, angle increment, then power.
    always_comb begin
        priority if (i_cmd.tgt) begin
            mul_a = $signed({2'b00, i_cfg.max_accel});
            mul_b = $signed({1'b0, i_cfg.tick_seconds});
        end else if (i_cmd.inc) begin
            mul_a = 25'(r_rate);
            mul_b = $signed({1'b0, i_cfg.tick_seconds});
        end else begin
            mul_a = $signed({1'b0, rate_mag});
            mul_b = $signed({11'd0, i_cfg.watts_per_rate});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Power is base*256 plus watts_per_rate*|rate|/4096, zero when disabled.
    assign power_sum = {1'b0, i_cfg.base_watts, 8'h00} + {3'b000, r_prod[32:12]};

    // Next values of the servo state.
    always_comb begin
        n_angle = r_angle;
        n_rate  = r_rate;
        n_trc   = r_trc;
        n_tac   = r_tac;
        n_mode  = r_mode;
        n_hit   = r_hit;
        if (i_cmd.decode) begin
            n_hit = 1'b0;
            unique case (r_cmd)
                CMD_TICK:  if (!i_cfg.enable) n_rate = '0;
                CMD_RATE: begin
                    n_trc  = clamp_q(r_val, mr_neg, mr_pos);
                    n_mode = 1'b0;
                end
                CMD_ANGLE: begin
                    n_tac  = clamp_q(r_val, lo_lim, hi_lim);
                    n_mode = 1'b1;
                end
                default: ;
            endcase
        end
        if (i_cmd.slew) begin
            if (err_mag > {1'b0, r_step}) n_rate = sat_q(slew_sum);
            else n_rate = r_tgt;
        end
        if (i_cmd.ang) begin
            if (ang_sat < lo_lim) begin
                n_angle = lo_lim;
                n_rate  = '0;
                n_hit   = 1'b1;
            end else if (ang_sat > hi_lim) begin
                n_angle = hi_lim;
                n_rate  = '0;
                n_hit   = 1'b1;
            end else begin
                n_angle = ang_sat;
            end
        end
    end

    // Servo state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= '0;
            r_rate      <= '0;
            r_trc       <= '0;
            r_tac       <= '0;
            r_mode      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_angle <= n_angle;
            r_rate  <= n_rate;
            r_trc   <= n_trc;
            r_tac   <= n_tac;
            r_mode  <= n_mode;
            r_hit   <= n_hit;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload and step registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_cmd;
            r_val <= $signed(i_in_value);
        end
        if (i_cmd.tgt) r_tgt <= tgt_clamped;
        if (i_cmd.err) begin
            r_err  <= sat_q(26'(r_tgt) - 26'(r_rate));
            r_step <= r_prod[42:20];
        end
        if (i_cmd.tgt || i_cmd.inc || i_cmd.pwr) r_prod <= mul_p;
        if (i_cmd.out_load) begin
            r_out_angle <= r_angle;
            r_out_rate  <= r_rate;
            r_out_near  <= (r_angle < lo_b) || (r_angle > hi_b);
            r_out_hit   <= r_hit;
            r_out_power <= i_cfg.enable ? power_sum : '0;
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.enable   = i_cfg.enable;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_angle = r_out_angle;
    assign o_out_rate  = r_out_rate;
    assign o_out_near  = r_out_near;
    assign o_out_hit   = r_out_hit;
    assign o_out_power = r_out_power;

    // A limit hit always leaves the rate at zero.
    a_hit_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_rate == '0)
        else $error("limit hit with nonzero rate");

    // With ordered limits the integrated angle stays inside them.
    a_angle_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ang && lo_lim <= hi_lim) |=>
        (r_angle >= $past(lo_lim) && r_angle <= $past(hi_lim)))
        else $error("angle outside limits after integration");

    // A disabled actuator reports no power.
    a_power_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !i_cfg.enable) |=> r_out_power == '0)
        else $error("power reported while disabled");

endmodule
